// ===== rtl/core/fdtd_pkg.sv =====
// Shared types, codes and constants of the periodic 1D field-update block.
package fdtd_pkg;

  localparam int unsigned DefaultGridCells  = 1024;
  localparam int unsigned DefaultFieldWidth = 32;

  localparam int unsigned FieldPortW = 32;
  localparam int unsigned CflW       = 17;
  localparam int unsigned DtW        = 16;
  localparam int unsigned CfgDataW   = 17;
  localparam int unsigned FracBits   = 16;

  localparam logic [CflW-1:0] CflMax   = 17'd65536;
  localparam logic [CflW-1:0] CflReset = 17'd32768;
  localparam logic [DtW-1:0]  DtReset  = 16'd3277;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ADV_B = 2'd2,
    OP_ADV_E = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_CFL_RATIO    = 2'd0,
    CFG_TIME_STEP    = 2'd1,
    CFG_ACTIVE_CELLS = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PASS,
    S_DONE
  } state_e;

  // One read step of a sweep, aligned with the memory read data.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic e_pass;
  } step_ctrl_t;

  // One write-back of a sweep.
  typedef struct packed {
    logic valid;
    logic last;
    logic e_pass;
    logic sat;
  } wb_ctrl_t;

endpackage

// ===== rtl/core/fdtd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module fdtd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/fdtd_update.sv =====
// Three-stage cell update pipeline: difference, multiply, round and saturate.
module fdtd_update #(
  parameter int unsigned Width = 32,
  parameter int unsigned IdxW  = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fdtd_pkg::step_ctrl_t         ctrl_i,
  input  logic [IdxW-1:0]              cell_i,
  input  logic [fdtd_pkg::CflW-1:0]    cfl_i,
  input  logic [fdtd_pkg::DtW-1:0]     dt_i,
  input  logic signed [Width-1:0]      ex_i,
  input  logic signed [Width-1:0]      ey_i,
  input  logic signed [Width-1:0]      bz_i,
  input  logic signed [Width-1:0]      jx_i,
  input  logic signed [Width-1:0]      jy_i,
  output fdtd_pkg::wb_ctrl_t           wb_o,
  output logic [IdxW-1:0]              wb_cell_o,
  output logic signed [Width-1:0]      wb_a_o,
  output logic signed [Width-1:0]      wb_x_o
);

  import fdtd_pkg::*;

  localparam int unsigned DiffW = Width + 1;
  localparam int unsigned PcW   = DiffW + CflW + 1;
  localparam int unsigned PjW   = Width + DtW + 1;
  localparam int unsigned RcW   = PcW - FracBits;
  localparam int unsigned RjW   = PjW - FracBits;
  localparam int unsigned SumW  = Width + 5;

  localparam logic signed [PcW-1:0] HalfC = PcW'(1) <<< (FracBits - 1);
  localparam logic signed [PjW-1:0] HalfJ = PjW'(1) <<< (FracBits - 1);
  localparam logic signed [Width-1:0] MaxVal = {1'b0, {(Width-1){1'b1}}};
  localparam logic signed [Width-1:0] MinVal = {1'b1, {(Width-1){1'b0}}};

  function automatic logic fits(input logic signed [SumW-1:0] v);
    logic [SumW-Width:0] hi;
    hi = v[SumW-1:Width-1];
    return (&hi) || !(|hi);
  endfunction

  function automatic logic signed [Width-1:0] clip(input logic signed [SumW-1:0] v);
    logic signed [Width-1:0] r;
    if (fits(v)) begin
      r = $signed(v[Width-1:0]);
    end else if (v[SumW-1]) begin
      r = MinVal;
    end else begin
      r = MaxVal;
    end
    return r;
  endfunction

  // Stage 1: neighbor difference against the previous step's data.
  logic signed [Width-1:0] ey_prev_q, bz_prev_q;
  logic signed [DiffW-1:0] d1;
  logic signed [Width-1:0] a1;

  always_comb begin
    if (ctrl_i.e_pass) begin
      d1 = $signed({bz_i[Width-1], bz_i}) - $signed({bz_prev_q[Width-1], bz_prev_q});
      a1 = ey_i;
    end else begin
      d1 = $signed({ey_i[Width-1], ey_i}) - $signed({ey_prev_q[Width-1], ey_prev_q});
      a1 = bz_prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      ey_prev_q <= ey_i;
      bz_prev_q <= bz_i;
    end
  end

  // Stage 2 registers and products.
  logic                    s2_v_q, s2_e_q, s2_last_q;
  logic [IdxW-1:0]         s2_cell_q;
  logic signed [DiffW-1:0] d2_q;
  logic signed [Width-1:0] a2_q, ex2_q, jx2_q, jy2_q;
  logic signed [PcW-1:0]   pc2;
  logic signed [PjW-1:0]   px2, py2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= ctrl_i.valid && !ctrl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_e_q    <= ctrl_i.e_pass;
    s2_last_q <= ctrl_i.last;
    s2_cell_q <= cell_i;
    d2_q      <= d1;
    a2_q      <= a1;
    ex2_q     <= ex_i;
    jx2_q     <= jx_i;
    jy2_q     <= jy_i;
  end

  assign pc2 = d2_q * $signed({1'b0, cfl_i});
  assign px2 = jx2_q * $signed({1'b0, dt_i});
  assign py2 = jy2_q * $signed({1'b0, dt_i});

  // Stage 3: round half up, subtract and saturate.
  logic                    s3_v_q, s3_e_q, s3_last_q;
  logic [IdxW-1:0]         s3_cell_q;
  logic signed [PcW-1:0]   pc3_q, pc_r;
  logic signed [PjW-1:0]   px3_q, py3_q, px_r, py_r;
  logic signed [Width-1:0] a3_q, ex3_q;
  logic signed [RcW-1:0]   rc;
  logic signed [RjW-1:0]   rx, ry;
  logic signed [SumW-1:0]  va, vx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_e_q    <= s2_e_q;
    s3_last_q <= s2_last_q;
    s3_cell_q <= s2_cell_q;
    pc3_q     <= pc2;
    px3_q     <= px2;
    py3_q     <= py2;
    a3_q      <= a2_q;
    ex3_q     <= ex2_q;
  end

  always_comb begin
    pc_r = pc3_q + HalfC;
    px_r = px3_q + HalfJ;
    py_r = py3_q + HalfJ;
    rc   = $signed(pc_r[PcW-1:FracBits]);
    rx   = $signed(px_r[PjW-1:FracBits]);
    ry   = $signed(py_r[PjW-1:FracBits]);
    va   = SumW'(a3_q) - SumW'(rc);
    if (s3_e_q) begin
      va = va - SumW'(ry);
    end
    vx   = SumW'(ex3_q) - SumW'(rx);
  end

  assign wb_o.valid  = s3_v_q;
  assign wb_o.last   = s3_last_q;
  assign wb_o.e_pass = s3_e_q;
  assign wb_o.sat    = s3_v_q && (!fits(va) || (s3_e_q && !fits(vx)));
  assign wb_cell_o   = s3_cell_q;
  assign wb_a_o      = clip(va);
  assign wb_x_o      = clip(vx);

endmodule

// ===== rtl/core/fdtd_field_update_1d.sv =====
// Top level of the periodic 1D Yee-grid field update block.
//
// Usage: one input beat is one operation on the grid. A write stores all five
// values of one cell, a read returns them, an advance-B beat sweeps Bz over
// all active cells and an advance-E beat sweeps Ex and Ey. Every input beat
// produces exactly one output beat carrying a status code and, for a read,
// the cell's values. The configuration channel sets the dt/dx ratio, dt and
// the active cell count; it may only be written while no operation is open.
// A write or an out-of-range access goes straight to the result state, while
// a read first passes through a read state. An advance over N active cells
// reads one cell per cycle from the field memories (N + 1 reads, one of them
// for the wrap-around neighbor) and writes results back through a
// three-stage arithmetic pipeline.
// The block takes one operation at a time; it accepts the next input beat as
// soon as the previous result sits in the output register, even while the
// receiver stalls that register. A finished result waits until the register
// is free. Reset clears control state and loads the configuration defaults;
// memory contents are undefined until written, and no clearing pass is run.
module fdtd_field_update_1d #(
  parameter int unsigned GRID_CELLS  = fdtd_pkg::DefaultGridCells,
  parameter int unsigned FIELD_WIDTH = fdtd_pkg::DefaultFieldWidth,
  localparam int unsigned IdxW = $clog2(GRID_CELLS)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [1:0]                              cfg_index_i,
  input  logic [fdtd_pkg::CfgDataW-1:0]           cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [1:0]                              operation_i,
  input  logic [IdxW-1:0]                         cell_index_i,
  input  logic signed [fdtd_pkg::FieldPortW-1:0]  e_x_in_i,
  input  logic signed [fdtd_pkg::FieldPortW-1:0]  e_y_in_i,
  input  logic signed [fdtd_pkg::FieldPortW-1:0]  b_z_in_i,
  input  logic signed [fdtd_pkg::FieldPortW-1:0]  j_x_in_i,
  input  logic signed [fdtd_pkg::FieldPortW-1:0]  j_y_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [1:0]                              status_o,
  output logic signed [fdtd_pkg::FieldPortW-1:0]  e_x_out_o,
  output logic signed [fdtd_pkg::FieldPortW-1:0]  e_y_out_o,
  output logic signed [fdtd_pkg::FieldPortW-1:0]  b_z_out_o,
  output logic signed [fdtd_pkg::FieldPortW-1:0]  j_x_out_o,
  output logic signed [fdtd_pkg::FieldPortW-1:0]  j_y_out_o
);

  import fdtd_pkg::*;

  // Stored words are at most 32 bits wide; values saturate to this width.
  localparam int unsigned EffW   = (FIELD_WIDTH > 32) ? 32 : FIELD_WIDTH;
  localparam int unsigned CountW = $clog2(GRID_CELLS + 1);

  localparam logic signed [EffW-1:0] MaxVal = {1'b0, {(EffW-1){1'b1}}};
  localparam logic signed [EffW-1:0] MinVal = {1'b1, {(EffW-1){1'b0}}};

  // Clamp a written port value to the stored width, without any flag.
  function automatic logic signed [EffW-1:0] sat_in(
    input logic signed [FieldPortW-1:0] v
  );
    logic [FieldPortW-EffW:0] hi;
    logic signed [EffW-1:0]   r;
    hi = v[FieldPortW-1:EffW-1];
    if ((&hi) || !(|hi)) begin
      r = $signed(v[EffW-1:0]);
    end else if (v[FieldPortW-1]) begin
      r = MinVal;
    end else begin
      r = MaxVal;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers. The port never stalls.
  // ---------------------------------------------------------------------
  logic [CflW-1:0]   cfl_q;
  logic [DtW-1:0]    dt_q;
  logic [CountW-1:0] active_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfl_q    <= CflReset;
      dt_q     <= DtReset;
      active_q <= CountW'(GRID_CELLS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CFL_RATIO:    cfl_q    <= cfg_data_i[CflW-1:0];
        CFG_TIME_STEP:    dt_q     <= cfg_data_i[DtW-1:0];
        CFG_ACTIVE_CELLS: active_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Effective cell count is held in [2, GRID_CELLS]; the ratio is capped at 1.0.
  logic [CountW-1:0] n_eff;
  logic [CflW-1:0]   cfl_eff;

  always_comb begin
    if (active_q > CountW'(GRID_CELLS)) begin
      n_eff = CountW'(GRID_CELLS);
    end else if (active_q < CountW'(2)) begin
      n_eff = CountW'(2);
    end else begin
      n_eff = active_q;
    end
  end

  assign cfl_eff = (cfl_q > CflMax) ? CflMax : cfl_q;

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  state_e            state_q, state_d;
  op_e               op_in, op_q;
  status_e           status_q;
  logic [CountW-1:0] k_q, k_m1, n_m1;
  logic              issue_done_q;
  logic              accept, idx_bad, cell_wr, cell_rd;
  logic              issuing, last_step, pass_e, out_load;
  logic [IdxW-1:0]   addr_b, addr_e, step_addr;
  wb_ctrl_t          wb;
  logic [IdxW-1:0]   wb_cell;
  logic signed [EffW-1:0] wb_a, wb_x;

  assign op_in   = op_e'(operation_i);
  assign accept  = in_valid_i && in_ready_o;
  assign idx_bad = CountW'(cell_index_i) >= n_eff;
  assign cell_wr = accept && (op_in == OP_WRITE) && !idx_bad;
  assign cell_rd = accept && (op_in == OP_READ) && !idx_bad;
  assign pass_e  = (op_q == OP_ADV_E);

  // A sweep issues N + 1 read steps k = 0..N. Step k delivers the data that
  // completes cell k - 1. The Bz sweep reads cell k and rereads cell 0 at
  // the end for the forward neighbor of the last cell; the E sweep first
  // reads the last cell for the backward neighbor of cell 0 and then cell
  // k - 1. Each cell is written back only after its own read, and the
  // neighbor field is never written during the same sweep, so reads and
  // write-backs never meet on one entry.
  assign issuing   = (state_q == S_PASS) && !issue_done_q;
  assign last_step = (k_q == n_eff);
  assign k_m1      = k_q - 1'b1;
  assign n_m1      = n_eff - 1'b1;
  assign addr_b    = last_step ? '0 : k_q[IdxW-1:0];
  assign addr_e    = (k_q == '0) ? n_m1[IdxW-1:0] : k_m1[IdxW-1:0];
  assign step_addr = pass_e ? addr_e : addr_b;

  // A finished result moves into the output register once that is free.
  assign out_load  = (state_q == S_DONE) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_in)
            OP_WRITE: state_d = S_DONE;
            OP_READ:  state_d = idx_bad ? S_DONE : S_READ;
            OP_ADV_B: state_d = S_PASS;
            OP_ADV_E: state_d = S_PASS;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_READ: state_d = S_DONE;
      S_PASS: begin
        if (wb.valid && wb.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= OP_WRITE;
      status_q     <= STAT_OK;
      k_q          <= '0;
      issue_done_q <= 1'b0;
    end else begin
      if (accept) begin
        op_q         <= op_in;
        status_q     <= (((op_in == OP_WRITE) || (op_in == OP_READ)) && idx_bad)
                        ? STAT_RANGE : STAT_OK;
        k_q          <= '0;
        issue_done_q <= 1'b0;
      end else if (issuing) begin
        k_q <= k_q + 1'b1;
        if (last_step) begin
          issue_done_q <= 1'b1;
        end
      end
      if (wb.valid && wb.sat) begin
        status_q <= STAT_SAT;
      end
    end
  end

  // Step control is registered alongside the memory read.
  step_ctrl_t      s1_ctrl_q;
  logic [IdxW-1:0] s1_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
    end else begin
      s1_ctrl_q.valid  <= issuing;
      s1_ctrl_q.first  <= (k_q == '0);
      s1_ctrl_q.last   <= last_step;
      s1_ctrl_q.e_pass <= pass_e;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cell_q <= k_m1[IdxW-1:0];
  end

  // ---------------------------------------------------------------------
  // Field memories. All five share one read address, Ex/Ey/Bz one write address.
  // ---------------------------------------------------------------------
  logic                   re;
  logic [IdxW-1:0]        raddr, waddr;
  logic                   we_ex, we_ey, we_bz;
  logic signed [EffW-1:0] wd_ex, wd_ey, wd_bz;
  logic signed [EffW-1:0] ex_rd, ey_rd, bz_rd, jx_rd, jy_rd;

  assign re    = issuing || cell_rd;
  assign raddr = issuing ? step_addr : cell_index_i;
  assign waddr = wb.valid ? wb_cell : cell_index_i;
  assign we_ex = cell_wr || (wb.valid && wb.e_pass);
  assign we_ey = cell_wr || (wb.valid && wb.e_pass);
  assign we_bz = cell_wr || (wb.valid && !wb.e_pass);
  assign wd_ex = wb.valid ? wb_x : sat_in(e_x_in_i);
  assign wd_ey = wb.valid ? wb_a : sat_in(e_y_in_i);
  assign wd_bz = wb.valid ? wb_a : sat_in(b_z_in_i);

  fdtd_ram #(.Width(EffW), .Depth(GRID_CELLS)) u_ram_ex (
    .clk_i, .we_i(we_ex), .waddr_i(waddr), .wdata_i(wd_ex),
    .re_i(re), .raddr_i(raddr), .rdata_o(ex_rd)
  );

  fdtd_ram #(.Width(EffW), .Depth(GRID_CELLS)) u_ram_ey (
    .clk_i, .we_i(we_ey), .waddr_i(waddr), .wdata_i(wd_ey),
    .re_i(re), .raddr_i(raddr), .rdata_o(ey_rd)
  );

  fdtd_ram #(.Width(EffW), .Depth(GRID_CELLS)) u_ram_bz (
    .clk_i, .we_i(we_bz), .waddr_i(waddr), .wdata_i(wd_bz),
    .re_i(re), .raddr_i(raddr), .rdata_o(bz_rd)
  );

  fdtd_ram #(.Width(EffW), .Depth(GRID_CELLS)) u_ram_jx (
    .clk_i, .we_i(cell_wr), .waddr_i(cell_index_i), .wdata_i(sat_in(j_x_in_i)),
    .re_i(re), .raddr_i(raddr), .rdata_o(jx_rd)
  );

  fdtd_ram #(.Width(EffW), .Depth(GRID_CELLS)) u_ram_jy (
    .clk_i, .we_i(cell_wr), .waddr_i(cell_index_i), .wdata_i(sat_in(j_y_in_i)),
    .re_i(re), .raddr_i(raddr), .rdata_o(jy_rd)
  );

  // ---------------------------------------------------------------------
  // Arithmetic pipeline.
  // ---------------------------------------------------------------------
  fdtd_update #(.Width(EffW), .IdxW(IdxW)) u_update (
    .clk_i,
    .rst_ni,
    .ctrl_i    (s1_ctrl_q),
    .cell_i    (s1_cell_q),
    .cfl_i     (cfl_eff),
    .dt_i      (dt_q),
    .ex_i      (ex_rd),
    .ey_i      (ey_rd),
    .bz_i      (bz_rd),
    .jx_i      (jx_rd),
    .jy_i      (jy_rd),
    .wb_o      (wb),
    .wb_cell_o (wb_cell),
    .wb_a_o    (wb_a),
    .wb_x_o    (wb_x)
  );

  // ---------------------------------------------------------------------
  // Output register. Read data stays in the memory output registers until
  // the result is loaded, since no read is issued in between.
  // ---------------------------------------------------------------------
  logic rd_ok;

  assign rd_ok = (op_q == OP_READ) && (status_q == STAT_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o  <= status_q;
      e_x_out_o <= rd_ok ? FieldPortW'(ex_rd) : '0;
      e_y_out_o <= rd_ok ? FieldPortW'(ey_rd) : '0;
      b_z_out_o <= rd_ok ? FieldPortW'(bz_rd) : '0;
      j_x_out_o <= rd_ok ? FieldPortW'(jx_rd) : '0;
      j_y_out_o <= rd_ok ? FieldPortW'(jy_rd) : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb.valid |-> (state_q == S_PASS))
    else $error("write-back outside a sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_wr |-> !wb.valid)
    else $error("cell write collides with a sweep write-back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb.valid && wb.last) |-> issue_done_q)
    else $error("sweep finished before all read steps were issued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_DONE))
    else $error("output beat raised without a finished operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing |-> (k_q <= n_eff))
    else $error("sweep step beyond the active cell count");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the periodic 1D Yee-grid field update block.
`timescale 1ns / 100ps

module tb_top;
  import fdtd_pkg::*;

  localparam int unsigned GridCells  = 1024;
  localparam int unsigned PhaseItems = 125;

  // Index 3 of the configuration channel addresses no register.
  localparam logic [1:0]  CfgNoReg = 2'd3;

  localparam logic [31:0] MaxQ = 32'h7FFF_FFFF;
  localparam logic [31:0] MinQ = 32'h8000_0000;
  localparam logic [31:0] OneQ = 32'h0001_0000;

  localparam longint FieldHi = 64'sd2147483647;
  localparam longint FieldLo = -64'sd2147483648;

  // Five Q16.16 words of one cell: [0] Ex, [1] Ey, [2] Bz, [3] Jx, [4] Jy.
  typedef logic [4:0][31:0] cell_vals_t;

  typedef struct packed {
    op_e        op;
    logic [9:0] idx;
    cell_vals_t vals;
  } grid_op_t;

  typedef struct packed {
    logic [1:0] status;
    cell_vals_t vals;
  } grid_result_t;

  // One row of the directed sequence: either a register write or an input beat,
  // the latter optionally with a hand-written result.
  typedef struct packed {
    logic                is_cfg;
    logic [1:0]          cfg_idx;
    logic [CfgDataW-1:0] cfg_data;
    grid_op_t            beat;
    logic                typed;
    grid_result_t        want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          operation_i;
  logic [9:0]          cell_index_i;
  logic signed [31:0]  e_x_in_i, e_y_in_i, b_z_in_i, j_x_in_i, j_y_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic signed [31:0]  e_x_out_o, e_y_out_o, b_z_out_o, j_x_out_o, j_y_out_o;

  fdtd_field_update_1d DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .cell_index_i (cell_index_i),
    .e_x_in_i     (e_x_in_i),
    .e_y_in_i     (e_y_in_i),
    .b_z_in_i     (b_z_in_i),
    .j_x_in_i     (j_x_in_i),
    .j_y_in_i     (j_y_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .e_x_out_o    (e_x_out_o),
    .e_y_out_o    (e_y_out_o),
    .b_z_out_o    (b_z_out_o),
    .j_x_out_o    (j_x_out_o),
    .j_y_out_o    (j_y_out_o)
  );

  // Shadow copy of the grid and of the configuration, as seen after each beat.
  logic signed [31:0] ex_grid [GridCells];
  logic signed [31:0] ey_grid [GridCells];
  logic signed [31:0] bz_grid [GridCells];
  logic signed [31:0] jx_grid [GridCells];
  logic signed [31:0] jy_grid [GridCells];
  bit                 cell_written [GridCells];
  longint             cfl_q16      = 32768;
  longint             dt_q16       = 3277;
  int unsigned        cells_in_use = GridCells;
  bit                 sweep_clipped;

  grid_result_t results_due [$];
  plan_row_t    directed_plan [$];
  int unsigned  mismatches;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  // Product of a Q16.16 value and an unsigned Q.16 factor, rounded half up.
  // The arithmetic shift of the biased product is the floor for both signs.
  function automatic longint scale_q16(input longint v, input longint f);
    return (v * f + 64'sd32768) >>> 16;
  endfunction

  // Saturate to the signed 32-bit field range; a clip is noted for the sweep.
  function automatic logic [31:0] clamp_q16(input longint v);
    if (v > FieldHi) begin
      sweep_clipped = 1'b1;
      return FieldHi[31:0];
    end
    if (v < FieldLo) begin
      sweep_clipped = 1'b1;
      return FieldLo[31:0];
    end
    return v[31:0];
  endfunction

  // Applies one accepted beat to the shadow grid and returns its result beat.
  function automatic grid_result_t predict_cell_op(input grid_op_t b);
    grid_result_t r;
    int unsigned  i, nb;
    longint       d, vx, vy;
    r = '0;
    sweep_clipped = 1'b0;
    case (b.op)
      OP_WRITE, OP_READ: begin
        if (b.idx >= cells_in_use) begin
          r.status = STAT_RANGE;
        end else if (b.op == OP_WRITE) begin
          ex_grid[b.idx] = b.vals[0];
          ey_grid[b.idx] = b.vals[1];
          bz_grid[b.idx] = b.vals[2];
          jx_grid[b.idx] = b.vals[3];
          jy_grid[b.idx] = b.vals[4];
          cell_written[b.idx] = 1'b1;
        end else begin
          r.vals = {jy_grid[b.idx], jx_grid[b.idx], bz_grid[b.idx],
                    ey_grid[b.idx], ex_grid[b.idx]};
        end
      end
      OP_ADV_B: begin
        // Forward difference of Ey; the last cell wraps to cell 0.
        for (i = 0; i < cells_in_use; i++) begin
          nb = (i + 1 == cells_in_use) ? 0 : i + 1;
          d = longint'(ey_grid[nb]) - longint'(ey_grid[i]);
          bz_grid[i] = clamp_q16(longint'(bz_grid[i]) - scale_q16(d, cfl_q16));
        end
        if (sweep_clipped) r.status = STAT_SAT;
      end
      default: begin
        // Backward difference of Bz; cell 0 wraps to the last cell. Ey takes
        // both terms before it saturates once.
        for (i = 0; i < cells_in_use; i++) begin
          nb = (i == 0) ? cells_in_use - 1 : i - 1;
          vx = longint'(ex_grid[i]) - scale_q16(longint'(jx_grid[i]), dt_q16);
          d  = longint'(bz_grid[i]) - longint'(bz_grid[nb]);
          vy = longint'(ey_grid[i]) - scale_q16(d, cfl_q16)
               - scale_q16(longint'(jy_grid[i]), dt_q16);
          ex_grid[i] = clamp_q16(vx);
          ey_grid[i] = clamp_q16(vy);
        end
        if (sweep_clipped) r.status = STAT_SAT;
      end
    endcase
    return r;
  endfunction

  function automatic cell_vals_t q_cell(input logic [31:0] ex, ey, bz, jx, jy);
    return {jy, jx, bz, ey, ex};
  endfunction

  function automatic void plan_cfg(input logic [1:0] idx, input logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg   = 1'b1;
    row.cfg_idx  = idx;
    row.cfg_data = data;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_op(input op_e op, input logic [9:0] idx, input cell_vals_t v);
    plan_row_t row;
    row = '0;
    row.beat = '{op: op, idx: idx, vals: v};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_checked(input op_e op, input logic [9:0] idx,
                                       input cell_vals_t v, input status_e st,
                                       input cell_vals_t want_vals);
    plan_row_t row;
    row = '0;
    row.beat  = '{op: op, idx: idx, vals: v};
    row.typed = 1'b1;
    row.want  = '{status: st, vals: want_vals};
    directed_plan.push_back(row);
  endfunction

  // Mostly small signed values so that fields evolve over many sweeps, with
  // full-range words and the extremes mixed in to reach saturation.
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(9))
      0: return $urandom();
      1: begin
        case ($urandom_range(3))
          0: return MaxQ;
          1: return MinQ;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // A cell inside the active range that has been written since reset.
  // Cell 0 is written by the directed part, so it is a safe fallback.
  function automatic logic [9:0] written_cell();
    logic [9:0] c;
    repeat (64) begin
      c = $urandom_range(cells_in_use - 1);
      if (cell_written[c]) return c;
    end
    return '0;
  endfunction

  // A sweep is allowed only once every active cell holds a written value.
  function automatic bit grid_filled();
    int unsigned i;
    for (i = 0; i < cells_in_use; i++) begin
      if (!cell_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic grid_op_t random_grid_op();
    grid_op_t    b;
    int unsigned r;
    b.vals = q_cell(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
    b.idx  = $urandom_range(cells_in_use - 1);
    r = $urandom_range(99);
    // A sweep over unwritten cells must not happen; write a cell instead.
    if (r >= 55 && !grid_filled()) r = 0;
    if (r < 25) begin
      b.op = OP_WRITE;
      if (cells_in_use < GridCells && $urandom_range(9) == 0) begin
        b.idx = $urandom_range(GridCells - 1, cells_in_use);
      end
    end else if (r < 55) begin
      b.op = OP_READ;
      if (cells_in_use < GridCells && $urandom_range(9) == 0) begin
        b.idx = $urandom_range(GridCells - 1, cells_in_use);
      end else begin
        b.idx = written_cell();
      end
    end else begin
      b.op = (r < 78) ? OP_ADV_B : OP_ADV_E;
    end
    return b;
  endfunction

  // Presents one input beat, possibly after a random gap, and holds it until
  // it is accepted. The result is predicted at the accepting edge. Valid is
  // left high; the next call or the next settle decides what follows.
  task automatic send_grid_op(input grid_op_t b, input logic typed, input grid_result_t want);
    grid_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= b.op;
    cell_index_i <= b.idx;
    e_x_in_i     <= b.vals[0];
    e_y_in_i     <= b.vals[1];
    b_z_in_i     <= b.vals[2];
    j_x_in_i     <= b.vals[3];
    j_y_in_i     <= b.vals[4];
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_cell_op(b);
    results_due.push_back(typed ? want : predicted);
  endtask

  // Drops the input valid and waits until every expected beat has arrived.
  // Every beat yields a result, so an empty store means the block is idle.
  task automatic settle_grid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    // The ratio saturates at 1.0 and the cell count into [2, GridCells].
    case (idx)
      CFG_CFL_RATIO:    cfl_q16 = (data > CflMax) ? longint'(CflMax) : longint'(data);
      CFG_TIME_STEP:    dt_q16 = longint'(data[DtW-1:0]);
      CFG_ACTIVE_CELLS: begin
        cells_in_use = data[10:0];
        if (cells_in_use < 2) cells_in_use = 2;
        if (cells_in_use > GridCells) cells_in_use = GridCells;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // The receiver draws a fresh stall decision every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Each delivered beat is compared with the oldest expectation, field by field.
  always @(posedge clk_i) begin : check_results
    grid_result_t got, want;
    bit           bad;
    int unsigned  k;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, j_y_out_o, j_x_out_o, b_z_out_o, e_y_out_o, e_x_out_o};
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result beat with nothing expected, status %0d", $realtime, status_o);
        end
      end else begin
        want = results_due.pop_front();
        bad = (got.status !== want.status);
        for (k = 0; k < 5; k++) bad |= (got.vals[k] !== want.vals[k]);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected status %0d Ex %h Ey %h Bz %h Jx %h Jy %h", $realtime,
                     want.status, want.vals[0], want.vals[1], want.vals[2],
                     want.vals[3], want.vals[4]);
            $display("%0t:      got status %0d Ex %h Ey %h Bz %h Jx %h Jy %h", $realtime,
                     got.status, got.vals[0], got.vals[1], got.vals[2],
                     got.vals[3], got.vals[4]);
          end
        end
      end
    end
  end

  initial begin : stimulus
    grid_op_t    b;
    int unsigned phase, c, k;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_CFL_RATIO;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    operation_i    = OP_WRITE;
    cell_index_i   = '0;
    e_x_in_i       = '0;
    e_y_in_i       = '0;
    b_z_in_i       = '0;
    j_x_in_i       = '0;
    j_y_in_i       = '0;
    out_ready_i    = 1'b1;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Directed part, starting from the reset configuration of 1024 cells.
    // Extreme words through both corner cells.
    plan_checked(OP_WRITE, 10'd0, q_cell(MaxQ, MinQ, '0, '1, OneQ), STAT_OK, '0);
    plan_checked(OP_READ, 10'd0, '0, STAT_OK, q_cell(MaxQ, MinQ, '0, '1, OneQ));
    plan_checked(OP_WRITE, 10'd1023, q_cell(MinQ, MaxQ, MaxQ, MinQ, '0), STAT_OK, '0);
    plan_checked(OP_READ, 10'd1023, '0, STAT_OK, q_cell(MinQ, MaxQ, MaxQ, MinQ, '0));
    // A cell count of zero is raised to two; accesses beyond it are refused.
    plan_cfg(CFG_ACTIVE_CELLS, '0);
    plan_checked(OP_READ, 10'd2, '0, STAT_RANGE, '0);
    plan_checked(OP_WRITE, 10'd1023, q_cell(OneQ, OneQ, OneQ, OneQ, OneQ), STAT_RANGE, '0);
    plan_checked(OP_READ, 10'd1023, '0, STAT_RANGE, '0);
    plan_checked(OP_WRITE, 10'd1, q_cell(OneQ, 32'h0002_0000, 32'h0000_8000, OneQ,
                 32'hFFFF_0000), STAT_OK, '0);
    // A ratio above 1.0 is held at 1.0, so Bz of cell 0 drops by Ey1 - Ey0,
    // which is more than the field range holds.
    plan_cfg(CFG_CFL_RATIO, 17'h1_FFFF);
    plan_checked(OP_ADV_B, 10'd0, '0, STAT_SAT, '0);
    plan_op(OP_READ, 10'd0, '0);
    plan_op(OP_READ, 10'd1, '0);
    plan_cfg(CFG_TIME_STEP, 17'h0_FFFF);
    plan_op(OP_ADV_E, 10'd1, q_cell('1, '1, '1, '1, '1));
    plan_op(OP_READ, 10'd0, '0);
    plan_op(OP_READ, 10'd1, '0);
    // Zero factors leave every field as it is.
    plan_cfg(CFG_CFL_RATIO, '0);
    plan_cfg(CFG_TIME_STEP, '0);
    plan_checked(OP_ADV_E, 10'd0, '0, STAT_OK, '0);
    plan_checked(OP_ADV_B, 10'd0, '0, STAT_OK, '0);
    // A write to the unused index must not reach the ratio.
    plan_cfg(CfgNoReg, 17'h1_FFFF);
    plan_op(OP_ADV_B, 10'd0, '0);
    plan_op(OP_READ, 10'd0, '0);
    // Counts above the grid are held at 1024; the refused write left cell 1023.
    plan_cfg(CFG_ACTIVE_CELLS, 17'h1_FFFF);
    plan_checked(OP_READ, 10'd1023, '0, STAT_OK, q_cell(MinQ, MaxQ, MaxQ, MinQ, '0));
    // Only the low eleven data bits set the count.
    plan_cfg(CFG_ACTIVE_CELLS, 17'h1_F802);
    plan_checked(OP_READ, 10'd2, '0, STAT_RANGE, '0);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < directed_plan.size(); k++) begin
      if (directed_plan[k].is_cfg) begin
        settle_grid();
        write_cfg(directed_plan[k].cfg_idx, directed_plan[k].cfg_data);
      end else begin
        send_grid_op(directed_plan[k].beat, directed_plan[k].typed, directed_plan[k].want);
      end
    end

    // Random phases, each with its own idling pattern and configuration.
    for (phase = 0; phase < 4; phase++) begin
      settle_grid();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_cfg(CFG_CFL_RATIO, CflMax);
          write_cfg(CFG_TIME_STEP, 17'h0_FFFF);
          write_cfg(CFG_ACTIVE_CELLS, 17'd2);
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
          write_cfg(CFG_CFL_RATIO, $urandom_range(65536));
          write_cfg(CFG_TIME_STEP, $urandom_range(65535));
          write_cfg(CFG_ACTIVE_CELLS, $urandom_range(32, 3));
        end
        2: begin
          // The full grid is never filled, so this phase only writes and reads,
          // spreading indexes over all 1024 cells.
          send_idle_pct  = 0;
          recv_stall_pct = 86;
          write_cfg(CFG_CFL_RATIO, '0);
          write_cfg(CFG_TIME_STEP, '0);
          write_cfg(CFG_ACTIVE_CELLS, 17'd1024);
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
          write_cfg(CFG_CFL_RATIO, $urandom_range(65536));
          write_cfg(CFG_TIME_STEP, $urandom_range(65535));
          write_cfg(CFG_ACTIVE_CELLS, $urandom_range(40, 2));
        end
      endcase
      // Below the full grid, fill every active cell with fresh content so that sweeps are legal.
      if (cells_in_use < GridCells) begin
        for (c = 0; c < cells_in_use; c++) begin
          b = random_grid_op();
          b.op  = OP_WRITE;
          b.idx = c;
          send_grid_op(b, 1'b0, '0);
        end
      end
      repeat (PhaseItems) send_grid_op(random_grid_op(), 1'b0, '0);
    end

    // Let any stray beat show up before the verdict.
    settle_grid();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
